// ===== hw/rtl/syslog_header_parser_core_macros.svh =====
// Assertion macros used by the checker file.
`ifndef SYSLOG_HEADER_PARSER_CORE_MACROS_SVH
`define SYSLOG_HEADER_PARSER_CORE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define SHL_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("syslog parser check failed");

// Next-cycle implication, disabled in reset.
`define SHL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("syslog parser check failed");

`endif

// ===== hw/rtl/shl_pkg.sv =====
package shl_pkg;

    localparam int TOKEN_CAP_DEF = 64;
    localparam int SD_CAP_DEF    = 256;
    localparam int MSG_CAP_DEF   = 1024;

    localparam int CNT_W = 12;
    localparam int CAP_W = 13;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [CNT_W-1:0] NUM_CHARS = 12'd7;
    localparam logic [CAP_W-1:0] NUM_CAP_M1 = 13'd7;

    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_LBR  = 8'h5B;
    localparam logic [7:0] CH_RBR  = 8'h5D;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_DASH = 8'h2D;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_CR   = 8'h0D;

    localparam logic [3:0] FC_PRI   = 4'd0;
    localparam logic [3:0] FC_VER   = 4'd1;
    localparam logic [3:0] FC_TS    = 4'd2;
    localparam logic [3:0] FC_SD    = 4'd7;
    localparam logic [3:0] FC_MSG   = 4'd8;
    localparam logic [3:0] FC_DELIM = 4'd9;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_LT     = 3'd1;
    localparam logic [2:0] ST_NO_GT     = 3'd2;
    localparam logic [2:0] ST_PRI_RANGE = 3'd3;
    localparam logic [2:0] ST_TOKEN     = 3'd4;

    localparam logic [1:0] NUM_LEAD  = 2'd0;
    localparam logic [1:0] NUM_SIGN  = 2'd1;
    localparam logic [1:0] NUM_DIGIT = 2'd2;
    localparam logic [1:0] NUM_END   = 2'd3;

    localparam logic [2:0] LAST_TOKEN = 3'd4;
    localparam int SD_NIL_BIT = 5;

    typedef enum logic [3:0] {
        PH_START,
        PH_PRI,
        PH_VER,
        PH_TOK,
        PH_SDSTART,
        PH_SDTOK,
        PH_SDBRK,
        PH_MSG,
        PH_DISCARD
    } t_phase;

    typedef struct packed {
        logic [3:0]       field_code;
        logic [7:0]       byte_out;
        logic             keep;
        logic [CNT_W-1:0] char_index;
        logic             done_res;
        logic [2:0]       status;
        logic [4:0]       facility;
        logic [2:0]       severity;
        logic [7:0]       version;
        logic [5:0]       nil_mask;
    } t_result;

    // dash && min(count, cap-1) == 1
    function automatic logic nil_hit(input logic dash, input logic [CNT_W-1:0] cnt,
                                     input logic [CAP_W-1:0] cap_m1);
        logic [CAP_W-1:0] c;
        logic [CAP_W-1:0] kept;
        c    = {1'b0, cnt};
        kept = (c < cap_m1) ? c : cap_m1;
        return dash && (kept == 13'd1);
    endfunction

endpackage

// ===== hw/rtl/shl_in_stage.sv =====
module shl_in_stage import shl_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    input  logic       i_advance,
    output logic       o_stall,
    output logic       o_full,
    output logic [7:0] o_data_byte,
    output logic       o_last_byte
);

    logic       r_full;
    logic [7:0] r_byte;
    logic       r_last;
    logic       load;

    assign o_stall = r_full && !i_advance;
    assign load    = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (load) begin
            r_full <= 1'b1;
        end else if (i_advance) begin
            r_full <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= i_data_byte;
            r_last <= i_last_byte;
        end
    end

    assign o_full      = r_full;
    assign o_data_byte = r_byte;
    assign o_last_byte = r_last;

endmodule

// ===== hw/rtl/shl_parser.sv =====
module shl_parser import shl_pkg::*; #(
    parameter int TOKEN_CAP = TOKEN_CAP_DEF,
    parameter int SD_CAP    = SD_CAP_DEF,
    parameter int MSG_CAP   = MSG_CAP_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_advance,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output t_result    o_result
);

    localparam logic [CAP_W-1:0] TOK_CAP_M1 = CAP_W'(TOKEN_CAP - 1);
    localparam logic [CAP_W-1:0] SD_CAP_M1  = CAP_W'(SD_CAP - 1);
    localparam logic [CAP_W-1:0] MSG_CAP_M1 = CAP_W'(MSG_CAP - 1);

    t_phase           r_phase, n_phase;
    logic [CNT_W-1:0] r_fc, n_fc;
    logic [7:0]       r_pri, n_pri;
    logic [1:0]       r_psd, n_psd;
    logic             r_neg, n_neg;
    logic [7:0]       r_ver, n_ver;
    logic             r_in_brk, n_in_brk;
    logic [2:0]       r_err, n_err;
    logic [5:0]       r_nil, n_nil;
    logic             r_dash, n_dash;
    logic [2:0]       r_tok, n_tok;

    logic             pc_en;
    logic [3:0]       pc_code;
    logic [CAP_W-1:0] pc_cap_m1;
    logic             nf_en;
    logic             nf_pri;
    logic             is_digit;
    logic [3:0]       digit;
    logic [10:0]      pri_acc;
    logic [2:0]       seen;
    logic [7:0]       b;
    t_result          res;

    assign b        = i_data_byte;
    assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    assign digit    = 4'(b - CH_ZERO);

    always_comb begin
        n_phase  = r_phase;
        n_fc     = r_fc;
        n_pri    = r_pri;
        n_psd    = r_psd;
        n_neg    = r_neg;
        n_ver    = r_ver;
        n_in_brk = r_in_brk;
        n_err    = r_err;
        n_nil    = r_nil;
        n_dash   = r_dash;
        n_tok    = r_tok;
        pc_en     = 1'b0;
        pc_code   = FC_DELIM;
        pc_cap_m1 = NUM_CAP_M1;
        nf_en     = 1'b0;
        nf_pri    = 1'b0;
        pri_acc   = '0;
        seen      = '0;
        res       = '0;
        res.field_code = FC_DELIM;
        res.byte_out   = b;
        res.done_res   = i_last_byte;

        case (r_phase)
            PH_START: begin
                if (b == CH_LT) begin
                    n_phase = PH_PRI;
                    n_fc    = '0;
                    n_psd   = NUM_LEAD;
                    n_neg   = 1'b0;
                end else begin
                    n_err   = ST_NO_LT;
                    n_phase = PH_DISCARD;
                end
            end
            PH_PRI: begin
                if (b == CH_GT) begin
                    if (r_neg ? (r_pri != 8'd0) : (r_pri > 8'd191)) begin
                        n_err   = ST_PRI_RANGE;
                        n_phase = PH_DISCARD;
                    end else begin
                        // negative zero counts as zero
                        if (r_neg) begin
                            n_pri = 8'd0;
                        end
                        n_phase = PH_VER;
                        n_fc    = '0;
                        n_psd   = NUM_LEAD;
                        n_neg   = 1'b0;
                    end
                end else if (r_fc < NUM_CHARS) begin
                    nf_en   = 1'b1;
                    nf_pri  = 1'b1;
                    pc_en   = 1'b1;
                    pc_code = FC_PRI;
                end else begin
                    n_err   = ST_NO_GT;
                    n_phase = PH_DISCARD;
                end
            end
            PH_VER: begin
                if (b == CH_SP) begin
                    n_phase = PH_TOK;
                    n_tok   = '0;
                    n_fc    = '0;
                end else if (r_fc < NUM_CHARS) begin
                    nf_en   = 1'b1;
                    pc_en   = 1'b1;
                    pc_code = FC_VER;
                end else begin
                    // overlong version spills into the timestamp
                    n_phase   = PH_TOK;
                    n_tok     = '0;
                    n_fc      = '0;
                    pc_en     = 1'b1;
                    pc_code   = FC_TS;
                    pc_cap_m1 = TOK_CAP_M1;
                end
            end
            PH_TOK: begin
                if (b == CH_SP) begin
                    if (r_fc == '0) begin
                        n_err   = ST_TOKEN;
                        n_phase = PH_DISCARD;
                    end else begin
                        if (nil_hit(r_dash, r_fc, TOK_CAP_M1)) begin
                            n_nil[r_tok] = 1'b1;
                        end
                        if (r_tok >= LAST_TOKEN) begin
                            n_phase = PH_SDSTART;
                        end else begin
                            n_tok = r_tok + 3'd1;
                        end
                        n_fc = '0;
                    end
                end else begin
                    pc_en     = 1'b1;
                    pc_code   = FC_TS + {1'b0, r_tok};
                    pc_cap_m1 = TOK_CAP_M1;
                end
            end
            PH_SDSTART: begin
                n_fc = '0;
                if (b == CH_LBR) begin
                    n_phase   = PH_SDBRK;
                    n_in_brk  = 1'b1;
                    pc_en     = 1'b1;
                    pc_code   = FC_SD;
                    pc_cap_m1 = SD_CAP_M1;
                end else if (b == CH_SP) begin
                    n_err   = ST_TOKEN;
                    n_phase = PH_DISCARD;
                end else begin
                    n_phase   = PH_SDTOK;
                    pc_en     = 1'b1;
                    pc_code   = FC_SD;
                    pc_cap_m1 = SD_CAP_M1;
                end
            end
            PH_SDTOK: begin
                if (b == CH_SP) begin
                    if (nil_hit(r_dash, r_fc, SD_CAP_M1)) begin
                        n_nil[SD_NIL_BIT] = 1'b1;
                    end
                    n_phase = PH_MSG;
                    n_fc    = '0;
                end else begin
                    pc_en     = 1'b1;
                    pc_code   = FC_SD;
                    pc_cap_m1 = SD_CAP_M1;
                end
            end
            PH_SDBRK: begin
                if (r_in_brk || (b == CH_LBR)) begin
                    pc_en     = 1'b1;
                    pc_code   = FC_SD;
                    pc_cap_m1 = SD_CAP_M1;
                    n_in_brk  = r_in_brk ? (b != CH_RBR) : 1'b1;
                end else if (b == CH_SP) begin
                    n_phase = PH_MSG;
                    n_fc    = '0;
                end else begin
                    n_phase   = PH_MSG;
                    n_fc      = '0;
                    pc_en     = 1'b1;
                    pc_code   = FC_MSG;
                    pc_cap_m1 = MSG_CAP_M1;
                end
            end
            PH_MSG: begin
                pc_en     = 1'b1;
                pc_code   = FC_MSG;
                pc_cap_m1 = MSG_CAP_M1;
            end
            default: begin
            end
        endcase

        // atoi-style number accumulation
        if (nf_en && (r_psd != NUM_END)) begin
            if (is_digit) begin
                if (nf_pri) begin
                    pri_acc = ({3'b0, r_pri} << 3) + ({3'b0, r_pri} << 1) + {7'b0, digit};
                    n_pri   = (pri_acc > 11'd192) ? 8'd192 : pri_acc[7:0];
                end else begin
                    n_ver = (r_ver << 3) + (r_ver << 1) + {4'b0, digit};
                end
                n_psd = NUM_DIGIT;
            end else if ((r_psd == NUM_LEAD) &&
                         ((b == CH_SP) || ((b >= CH_TAB) && (b <= CH_CR)))) begin
                n_psd = NUM_LEAD;
            end else if ((r_psd == NUM_LEAD) && ((b == CH_PLUS) || (b == CH_DASH))) begin
                n_neg = (b == CH_DASH);
                n_psd = NUM_SIGN;
            end else begin
                n_psd = NUM_END;
            end
        end

        // tag the byte and advance the field counter
        if (pc_en) begin
            if (n_fc == '0) begin
                n_dash = (b == CH_DASH);
            end
            res.field_code = pc_code;
            res.char_index = n_fc;
            res.keep       = ({1'b0, n_fc} < pc_cap_m1);
            if (n_fc != CNT_MAX) begin
                n_fc = n_fc + 12'd1;
            end
        end

        if (i_last_byte) begin
            if (n_err == ST_OK) begin
                case (n_phase)
                    PH_PRI: begin
                        n_err = ST_NO_GT;
                    end
                    PH_VER: begin
                        n_err = ST_TOKEN;
                    end
                    PH_TOK: begin
                        seen = n_tok + {2'b0, (n_fc != '0)};
                        if ((n_fc != '0) && nil_hit(n_dash, n_fc, TOK_CAP_M1)) begin
                            n_nil[n_tok] = 1'b1;
                        end
                        if (seen < 3'd5) begin
                            n_err = ST_TOKEN;
                        end
                    end
                    PH_SDTOK: begin
                        if (nil_hit(n_dash, n_fc, SD_CAP_M1)) begin
                            n_nil[SD_NIL_BIT] = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            res.status = n_err;
            if (n_err == ST_OK) begin
                res.facility = n_pri[7:3];
                res.severity = n_pri[2:0];
                res.version  = n_neg ? (8'd0 - n_ver) : n_ver;
                res.nil_mask = n_nil;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_advance && i_last_byte)) begin
            r_phase  <= PH_START;
            r_fc     <= '0;
            r_pri    <= '0;
            r_psd    <= NUM_LEAD;
            r_neg    <= 1'b0;
            r_ver    <= '0;
            r_in_brk <= 1'b0;
            r_err    <= ST_OK;
            r_nil    <= '0;
            r_dash   <= 1'b0;
            r_tok    <= '0;
        end else if (i_advance) begin
            r_phase  <= n_phase;
            r_fc     <= n_fc;
            r_pri    <= n_pri;
            r_psd    <= n_psd;
            r_neg    <= n_neg;
            r_ver    <= n_ver;
            r_in_brk <= n_in_brk;
            r_err    <= n_err;
            r_nil    <= n_nil;
            r_dash   <= n_dash;
            r_tok    <= n_tok;
        end
    end

    assign o_result = res;

endmodule

// ===== hw/rtl/syslog_header_parser_core.sv =====
// Syslog header parser: tags each message byte with its field and reports on the last.
// A request passes through the input register, then the result register, before its result is valid.
// Throughput: one byte per cycle while the output is not stalled; the parse state updates in a single step per byte.
// A stalled result is held; the input register still takes the next byte only if it is empty.
// Reset (i_rst_n low, synchronous) empties both registers and returns the parse state
// to waiting for the opening bracket; the parse state alone also returns there after each last byte.
module syslog_header_parser_core import shl_pkg::*; #(
    parameter int TOKEN_CAP = TOKEN_CAP_DEF,
    parameter int SD_CAP    = SD_CAP_DEF,
    parameter int MSG_CAP   = MSG_CAP_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_field_code,
    output logic [7:0]  o_byte_out,
    output logic        o_keep,
    output logic [11:0] o_char_index,
    output logic        o_done_res,
    output logic [2:0]  o_status,
    output logic [4:0]  o_facility,
    output logic [2:0]  o_severity,
    output logic [7:0]  o_version,
    output logic [5:0]  o_nil_mask
);

    logic       in_full;
    logic [7:0] in_byte;
    logic       in_last;
    logic       advance;
    t_result    step_res;
    t_result    r_res;
    logic       r_out_valid;

    assign advance = in_full && (!r_out_valid || !i_stall);

    shl_in_stage u_in (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_advance   (advance),
        .o_stall     (o_stall),
        .o_full      (in_full),
        .o_data_byte (in_byte),
        .o_last_byte (in_last)
    );

    shl_parser #(
        .TOKEN_CAP (TOKEN_CAP),
        .SD_CAP    (SD_CAP),
        .MSG_CAP   (MSG_CAP)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_data_byte (in_byte),
        .i_last_byte (in_last),
        .o_result    (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // hold the result while stalled
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= step_res;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_field_code = r_res.field_code;
    assign o_byte_out   = r_res.byte_out;
    assign o_keep       = r_res.keep;
    assign o_char_index = r_res.char_index;
    assign o_done_res   = r_res.done_res;
    assign o_status     = r_res.status;
    assign o_facility   = r_res.facility;
    assign o_severity   = r_res.severity;
    assign o_version    = r_res.version;
    assign o_nil_mask   = r_res.nil_mask;

endmodule

// ===== hw/rtl/shl_checker.sv =====
`include "syslog_header_parser_core_macros.svh"

module shl_checker import shl_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic [7:0]  i_data_byte,
    input logic        i_last_byte,
    input logic        o_valid,
    input logic        i_stall,
    input logic [3:0]  o_field_code,
    input logic [7:0]  o_byte_out,
    input logic        o_keep,
    input logic [11:0] o_char_index,
    input logic        o_done_res,
    input logic [2:0]  o_status,
    input logic [4:0]  o_facility,
    input logic [2:0]  o_severity,
    input logic [7:0]  o_version,
    input logic [5:0]  o_nil_mask
);

    logic [8:0]  in_word;
    logic [12:0] out_word;
    logic        summary_zero;

    assign in_word      = {i_data_byte, i_last_byte};
    assign out_word     = {o_byte_out, o_field_code, o_done_res};
    assign summary_zero = (o_facility == 5'd0) && (o_severity == 3'd0) &&
                          (o_version == 8'd0) && (o_nil_mask == 6'd0);

    `SHL_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, i_valid && o_stall, i_valid && $stable(in_word))
    `SHL_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(out_word))
    `SHL_ASSERT_SAME(a_summary_only_done, i_clk, i_rst_n, o_valid && !o_done_res, (o_status == ST_OK) && summary_zero)
    `SHL_ASSERT_SAME(a_error_clears, i_clk, i_rst_n, o_valid && (o_status != ST_OK), summary_zero)
    `SHL_ASSERT_SAME(a_delim_untagged, i_clk, i_rst_n, o_valid && (o_field_code == FC_DELIM), !o_keep && (o_char_index == 12'd0))

endmodule

bind syslog_header_parser_core shl_checker u_shl_checker (.*);

// ===== tb/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import shl_pkg::*;

    localparam int TOK_CAP = TOKEN_CAP_DEF;
    localparam int SDF_CAP = SD_CAP_DEF;
    localparam int TXT_CAP = MSG_CAP_DEF;
    localparam int NUM_CAP = 8;
    localparam int PHASE_ITEMS = 300;
    localparam int GAP_PCT [4] = '{0, 78, 0, 22};
    localparam int STALL_PCT [4] = '{0, 0, 78, 22};

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_data_byte;
    logic        i_last_byte;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [3:0]  o_field_code;
    logic [7:0]  o_byte_out;
    logic        o_keep;
    logic [11:0] o_char_index;
    logic        o_done_res;
    logic [2:0]  o_status;
    logic [4:0]  o_facility;
    logic [2:0]  o_severity;
    logic [7:0]  o_version;
    logic [5:0]  o_nil_mask;

    syslog_header_parser_core i_dut (.*);

    always #5 i_clk = ~i_clk;

    // Parser state mirrored for prediction
    t_phase           ps;
    logic [CNT_W-1:0] cnt;
    logic [7:0]       pri_acc;
    logic [1:0]       num_st;
    logic             neg;
    logic [7:0]       ver_acc;
    logic             in_grp;
    logic [2:0]       err;
    logic [5:0]       nil;
    logic             dash;
    logic [2:0]       tok;

    t_result    next_tag;
    t_result    want_tags [$];
    logic [7:0] msg_q [$];
    int         bad_count = 0;
    int         gap_pct = 0;
    int         stall_pct = 0;

    typedef struct packed {
        logic [7:0] data;
        logic       eom;
        logic       pin;
        logic [3:0] code;
        logic [2:0] st;
    } t_row;

    // Rows with pin set carry the field code and status typed in by hand.
    localparam t_row DIR_ROWS [29] = '{
        '{8'h00,   1'b1, 1'b1, FC_DELIM, ST_NO_LT},
        '{CH_LT,   1'b1, 1'b1, FC_DELIM, ST_NO_GT},
        '{CH_LT,   1'b0, 1'b1, FC_DELIM, ST_OK},
        '{8'h31,   1'b0, 1'b1, FC_PRI,   ST_OK},
        '{8'h39,   1'b0, 1'b1, FC_PRI,   ST_OK},
        '{8'h32,   1'b0, 1'b1, FC_PRI,   ST_OK},
        '{CH_GT,   1'b1, 1'b1, FC_DELIM, ST_PRI_RANGE},
        '{CH_LT,   1'b0, 1'b1, FC_DELIM, ST_OK},
        '{CH_DASH, 1'b0, 1'b0, FC_DELIM, ST_OK},
        '{CH_ZERO, 1'b0, 1'b0, FC_DELIM, ST_OK},
        '{CH_GT,   1'b0, 1'b1, FC_DELIM, ST_OK},
        '{8'hFF,   1'b1, 1'b1, FC_VER,   ST_TOKEN},
        '{CH_LT,   1'b0, 1'b1, FC_DELIM, ST_OK},
        '{8'h31,   1'b0, 1'b1, FC_PRI,   ST_OK},
        '{8'h39,   1'b0, 1'b1, FC_PRI,   ST_OK},
        '{8'h31,   1'b0, 1'b1, FC_PRI,   ST_OK},
        '{CH_GT,   1'b0, 1'b1, FC_DELIM, ST_OK},
        '{8'h31,   1'b0, 1'b1, FC_VER,   ST_OK},
        '{CH_SP,   1'b0, 1'b1, FC_DELIM, ST_OK},
        '{CH_DASH, 1'b0, 1'b1, FC_TS,    ST_OK},
        '{CH_SP,   1'b0, 1'b0, FC_DELIM, ST_OK},
        '{CH_DASH, 1'b0, 1'b0, FC_DELIM, ST_OK},
        '{CH_SP,   1'b0, 1'b0, FC_DELIM, ST_OK},
        '{CH_DASH, 1'b0, 1'b0, FC_DELIM, ST_OK},
        '{CH_SP,   1'b0, 1'b0, FC_DELIM, ST_OK},
        '{CH_DASH, 1'b0, 1'b0, FC_DELIM, ST_OK},
        '{CH_SP,   1'b0, 1'b0, FC_DELIM, ST_OK},
        '{CH_DASH, 1'b0, 1'b0, FC_DELIM, ST_OK},
        '{CH_SP,   1'b1, 1'b1, FC_DELIM, ST_OK}
    };

    task automatic reset_parser();
        ps = PH_START;
        cnt = '0;
        pri_acc = '0;
        num_st = NUM_LEAD;
        neg = 1'b0;
        ver_acc = '0;
        in_grp = 1'b0;
        err = ST_OK;
        nil = '0;
        dash = 1'b0;
        tok = '0;
    endtask

    task automatic abort_msg(input logic [2:0] code);
        err = code;
        ps = PH_DISCARD;
    endtask

    task automatic start_number();
        cnt = '0;
        num_st = NUM_LEAD;
        neg = 1'b0;
    endtask

    // atoi-style accumulation: blanks, one sign, digits, then stop at anything else
    task automatic feed_digit(input logic [7:0] b, input logic is_pri);
        int v;
        if (num_st == NUM_END) return;
        if (b >= CH_ZERO && b <= CH_NINE) begin
            if (is_pri) begin
                v = int'(pri_acc) * 10 + int'(b - CH_ZERO);
                pri_acc = (v > 192) ? 8'd192 : 8'(v);
            end else begin
                ver_acc = 8'(int'(ver_acc) * 10 + int'(b - CH_ZERO));
            end
            num_st = NUM_DIGIT;
            return;
        end
        if (num_st == NUM_LEAD) begin
            if (b == CH_SP || (b >= CH_TAB && b <= CH_CR)) return;
            if (b == CH_PLUS || b == CH_DASH) begin
                neg = (b == CH_DASH);
                num_st = NUM_SIGN;
                return;
            end
        end
        num_st = NUM_END;
    endtask

    task automatic tag_byte(input logic [7:0] b, input logic [3:0] code, input int cap);
        if (cnt == 0) dash = (b == CH_DASH);
        next_tag.field_code = code;
        next_tag.char_index = cnt;
        next_tag.keep = (int'(cnt) + 1 < cap);
        if (cnt != CNT_MAX) cnt = cnt + 1'b1;
    endtask

    task automatic close_token(input int bit_i, input int cap);
        int kept;
        kept = (int'(cnt) < cap - 1) ? int'(cnt) : cap - 1;
        if (dash && kept == 1) nil[bit_i] = 1'b1;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic eom);
        int seen;
        next_tag = '0;
        next_tag.field_code = FC_DELIM;
        next_tag.byte_out = b;
        case (ps)
            PH_START: begin
                if (b == CH_LT) begin
                    ps = PH_PRI;
                    start_number();
                end else begin
                    abort_msg(ST_NO_LT);
                end
            end
            PH_PRI: begin
                if (b == CH_GT) begin
                    if (neg ? (pri_acc != 0) : (pri_acc > 8'd191)) begin
                        abort_msg(ST_PRI_RANGE);
                    end else begin
                        if (neg) pri_acc = '0;
                        ps = PH_VER;
                        start_number();
                    end
                end else if (cnt < NUM_CHARS) begin
                    feed_digit(b, 1'b1);
                    tag_byte(b, FC_PRI, NUM_CAP);
                end else begin
                    abort_msg(ST_NO_GT);
                end
            end
            PH_VER: begin
                if (b == CH_SP) begin
                    ps = PH_TOK;
                    tok = '0;
                    cnt = '0;
                end else if (cnt < NUM_CHARS) begin
                    feed_digit(b, 1'b0);
                    tag_byte(b, FC_VER, NUM_CAP);
                end else begin
                    // overlong version runs straight into the timestamp
                    ps = PH_TOK;
                    tok = '0;
                    cnt = '0;
                    tag_byte(b, FC_TS, TOK_CAP);
                end
            end
            PH_TOK: begin
                if (b == CH_SP) begin
                    if (cnt == 0) begin
                        abort_msg(ST_TOKEN);
                    end else begin
                        close_token(tok, TOK_CAP);
                        if (tok >= LAST_TOKEN) ps = PH_SDSTART;
                        else tok = tok + 1'b1;
                        cnt = '0;
                    end
                end else begin
                    tag_byte(b, FC_TS + 4'(tok), TOK_CAP);
                end
            end
            PH_SDSTART: begin
                cnt = '0;
                if (b == CH_LBR) begin
                    ps = PH_SDBRK;
                    in_grp = 1'b1;
                    tag_byte(b, FC_SD, SDF_CAP);
                end else if (b == CH_SP) begin
                    abort_msg(ST_TOKEN);
                end else begin
                    ps = PH_SDTOK;
                    tag_byte(b, FC_SD, SDF_CAP);
                end
            end
            PH_SDTOK: begin
                if (b == CH_SP) begin
                    close_token(SD_NIL_BIT, SDF_CAP);
                    ps = PH_MSG;
                    cnt = '0;
                end else begin
                    tag_byte(b, FC_SD, SDF_CAP);
                end
            end
            PH_SDBRK: begin
                if (in_grp) begin
                    tag_byte(b, FC_SD, SDF_CAP);
                    if (b == CH_RBR) in_grp = 1'b0;
                end else if (b == CH_LBR) begin
                    tag_byte(b, FC_SD, SDF_CAP);
                    in_grp = 1'b1;
                end else if (b == CH_SP) begin
                    ps = PH_MSG;
                    cnt = '0;
                end else begin
                    ps = PH_MSG;
                    cnt = '0;
                    tag_byte(b, FC_MSG, TXT_CAP);
                end
            end
            PH_MSG: tag_byte(b, FC_MSG, TXT_CAP);
            default: ;
        endcase

        if (eom) begin
            if (err == ST_OK) begin
                case (ps)
                    PH_PRI: abort_msg(ST_NO_GT);
                    PH_VER: abort_msg(ST_TOKEN);
                    PH_TOK: begin
                        seen = int'(tok) + ((cnt > 0) ? 1 : 0);
                        if (cnt > 0) close_token(tok, TOK_CAP);
                        if (seen < 5) abort_msg(ST_TOKEN);
                    end
                    PH_SDTOK: close_token(SD_NIL_BIT, SDF_CAP);
                    default: ;
                endcase
            end
            next_tag.done_res = 1'b1;
            next_tag.status = err;
            if (err == ST_OK) begin
                next_tag.facility = pri_acc[7:3];
                next_tag.severity = pri_acc[2:0];
                next_tag.version = neg ? 8'(256 - int'(ver_acc)) : ver_acc;
                next_tag.nil_mask = nil;
            end
            reset_parser();
        end
    endtask

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_byte(input logic [7:0] b, input logic eom, input logic pin,
                             input logic [3:0] pin_code, input logic [2:0] pin_st);
        while ($urandom_range(0, 99) < gap_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= eom;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        parse_byte(b, eom);
        if (pin) begin
            next_tag.field_code = pin_code;
            next_tag.status = pin_st;
        end
        want_tags.push_back(next_tag);
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] rand_except(input logic [7:0] x);
        logic [7:0] v;
        do v = 8'($urandom_range(0, 255)); while (v == x);
        return v;
    endfunction

    task automatic push_text(input string s);
        int k;
        for (k = 0; k < s.len(); k++) msg_q.push_back(8'(s[k]));
    endtask

    task automatic push_rand(input int n, input logic [7:0] x);
        repeat (n) msg_q.push_back(rand_except(x));
    endtask

    // Mostly well-formed messages with random content; some noise and broken ones.
    task automatic build_msg();
        int kind, t, k, n;
        msg_q.delete();
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
            repeat ($urandom_range(1, 12)) msg_q.push_back(8'($urandom_range(0, 255)));
            return;
        end else begin
            msg_q.push_back(kind < 11 ? 8'($urandom_range(0, 255)) : CH_LT);
            t = $urandom_range(0, 9);
            case (t)
                6: push_text($sformatf("%0d", $urandom_range(192, 9999)));
                7: begin
                    repeat ($urandom_range(0, 2))
                        msg_q.push_back($urandom_range(0, 1) ? CH_SP
                                        : 8'(CH_TAB + $urandom_range(0, 4)));
                    msg_q.push_back($urandom_range(0, 1) ? CH_PLUS : CH_DASH);
                    push_text($sformatf("%0d", $urandom_range(0, 1) ? 0
                                        : $urandom_range(0, 300)));
                end
                8: repeat ($urandom_range(0, 8))
                    msg_q.push_back($urandom_range(0, 1) ? 8'(CH_ZERO + $urandom_range(0, 9))
                                    : 8'($urandom_range(0, 255)));
                9: repeat (8) msg_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
                default: push_text($sformatf("%0d", $urandom_range(0, 191)));
            endcase
            msg_q.push_back(CH_GT);

            t = $urandom_range(0, 9);
            if (t < 6) begin
                push_text($sformatf("%0d", $urandom_range(0, 999)));
            end else if (t == 6) begin
                msg_q.push_back(CH_DASH);
                push_text($sformatf("%0d", $urandom_range(0, 999)));
            end else if (t == 7) begin
                repeat ($urandom_range(8, 10)) msg_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
            end else if (t == 8) begin
                push_rand($urandom_range(0, 7), CH_SP);
            end
            if (t != 7 || $urandom_range(0, 1)) msg_q.push_back(CH_SP);

            for (k = 0; k < 5; k++) begin
                t = $urandom_range(0, 99);
                if (t < 35) begin
                    msg_q.push_back(CH_DASH);
                end else if (t < 37) begin
                    // leave the token empty
                end else if (t < 40) begin
                    push_rand($urandom_range(60, 70), CH_SP);
                end else if (t < 48) begin
                    msg_q.push_back(CH_DASH);
                    push_rand($urandom_range(1, 3), CH_SP);
                end else begin
                    push_rand($urandom_range(1, 8), CH_SP);
                end
                msg_q.push_back(CH_SP);
            end

            t = $urandom_range(0, 99);
            if (t < 30) begin
                msg_q.push_back(CH_DASH);
            end else if (t < 65) begin
                repeat ($urandom_range(1, 3)) begin
                    msg_q.push_back(CH_LBR);
                    push_rand($urandom_range(0, 8), CH_RBR);
                    msg_q.push_back(CH_RBR);
                end
            end else if (t < 67) begin
                msg_q.push_back(CH_LBR);
                push_rand($urandom_range(250, 270), CH_RBR);
                msg_q.push_back(CH_RBR);
            end else if (t < 69) begin
                push_rand($urandom_range(250, 270), CH_SP);
            end else if (t < 97) begin
                push_rand($urandom_range(1, 8), CH_SP);
            end
            if ($urandom_range(0, 9) < 8) msg_q.push_back(CH_SP);
        end

        t = $urandom_range(0, 99);
        if (t < 2) n = $urandom_range(1020, 1040);
        else n = $urandom_range(0, 20);
        repeat (n) msg_q.push_back(8'($urandom_range(0, 255)));

        // cut some messages short
        if ($urandom_range(0, 99) < 12) begin
            n = $urandom_range(1, msg_q.size());
            while (msg_q.size() > n) void'(msg_q.pop_back());
        end
    endtask

    always @(negedge i_clk) i_stall <= ($urandom_range(0, 99) < stall_pct);

    task automatic check_field(input string name, input logic [11:0] want,
                               input logic [11:0] got);
        if (got !== want) begin
            bad_count++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (want_tags.size() == 0) begin
                bad_count++;
                $display("%0t: result with none expected, expected nothing actual byte %02h",
                         $time, o_byte_out);
            end else begin
                want = want_tags.pop_front();
                check_field("field_code", want.field_code, o_field_code);
                check_field("byte_out", want.byte_out, o_byte_out);
                check_field("keep", want.keep, o_keep);
                check_field("char_index", want.char_index, o_char_index);
                check_field("done_res", want.done_res, o_done_res);
                check_field("status", want.status, o_status);
                check_field("facility", want.facility, o_facility);
                check_field("severity", want.severity, o_severity);
                check_field("version", want.version, o_version);
                check_field("nil_mask", want.nil_mask, o_nil_mask);
            end
        end
    end

    initial begin
        int ph, k, sent;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data_byte = '0;
        i_last_byte = 1'b0;
        reset_parser();
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIR_ROWS[r])
            send_byte(DIR_ROWS[r].data, DIR_ROWS[r].eom, DIR_ROWS[r].pin,
                      DIR_ROWS[r].code, DIR_ROWS[r].st);

        for (ph = 0; ph < 4; ph++) begin
            gap_pct = GAP_PCT[ph];
            stall_pct = STALL_PCT[ph];
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                build_msg();
                for (k = 0; k < msg_q.size(); k++)
                    send_byte(msg_q[k], k == msg_q.size() - 1, 1'b0, FC_DELIM, ST_OK);
                sent += msg_q.size();
            end
            // hold off until the pipeline has drained
            i_valid <= 1'b0;
            do @(negedge i_clk); while (want_tags.size() != 0);
        end

        repeat (8) @(posedge i_clk);
        if (bad_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/shl_pkg.sv
hw/rtl/shl_in_stage.sv
hw/rtl/shl_parser.sv
hw/rtl/syslog_header_parser_core.sv
hw/rtl/shl_checker.sv
tb/testbench.sv
